/* sv/sled_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants for the string literal escape decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

  // Longest literal is MAX_LEN-1 decoded bytes
  localparam int MAX_LEN = 512;
  localparam int CNT_W   = $clog2(MAX_LEN);

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_UNTERM   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_literal;
    logic       end_of_text;
  } sled_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [8:0] out_length;
    logic       last;
  } sled_out_t;

  // Up to two results per request, written to the result queue together
  typedef struct packed {
    logic      v0;
    logic      v1;
    sled_out_t r0;
    sled_out_t r1;
  } sled_push_t;

endpackage
`default_nettype wire

/* sv/sled_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_decode
// Escape decoding state machine: while en is high, one registered request in,
// up to two results out per cycle.
// ----------------------------------------------------------------------------
module sled_decode (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  sled_pkg::sled_in_t   item,
  output sled_pkg::sled_push_t push
);
  import sled_pkg::*;

  typedef enum logic [2:0] {
    IDLE = 3'd0,
    BODY = 3'd1,
    ESC  = 3'd2,
    OCT  = 3'd3,
    HEX  = 3'd4
  } mode_t;

  typedef struct packed {
    logic             ok;
    sled_out_t        res;
    logic [CNT_W-1:0] cnt;
  } emit_t;

  typedef struct packed {
    logic             has;
    sled_out_t        res;
    mode_t            mode;
    logic [CNT_W-1:0] cnt;
  } body_t;

  mode_t            mode, mode_next;
  logic [8:0]       escape_value, escape_value_next;
  logic [1:0]       digit_count, digit_count_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  function automatic sled_out_t mk(input logic [1:0] kind, input logic [7:0] b,
                                   input logic [8:0] len);
    sled_out_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.out_length = len;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [8:0] len_field(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[8:0];
  endfunction

  function automatic emit_t emit_eval(input logic [7:0] b, input logic [CNT_W-1:0] c);
    emit_t e;
    if (c >= CNT_W'(MAX_LEN - 1)) begin
      e.ok  = 1'b0;
      e.res = mk(KIND_TOO_LONG, 8'd0, 9'd0);
      e.cnt = c;
    end else begin
      e.ok  = 1'b1;
      e.res = mk(KIND_BYTE, b, 9'd0);
      e.cnt = c + CNT_W'(1);
    end
    return e;
  endfunction

  function automatic body_t body_eval(input logic [7:0] b, input logic [CNT_W-1:0] c);
    body_t bd;
    emit_t e;
    bd.cnt = c;
    if (b == 8'h22) begin
      bd.has  = 1'b1;
      bd.res  = mk(KIND_COMPLETE, 8'd0, len_field(c));
      bd.mode = IDLE;
    end else if (b == 8'h5c) begin
      bd.has  = 1'b0;
      bd.res  = '0;
      bd.mode = ESC;
    end else begin
      e       = emit_eval(b, c);
      bd.has  = 1'b1;
      bd.res  = e.res;
      bd.cnt  = e.cnt;
      bd.mode = e.ok ? BODY : IDLE;
    end
    return bd;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] h;
    if (b >= 8'h30 && b <= 8'h39)      h = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) h = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) h = {1'b1, 4'(b - 8'h37)};
    else                               h = 5'd0;
    return h;
  endfunction

  logic       v0, v1;
  sled_out_t  r0, r1;
  emit_t      e;
  body_t      bd;
  logic       is_oct;
  logic [4:0] hv;
  logic [8:0] ev_new;
  logic [2:0] dc_inc;

  always_comb begin
    mode_next         = mode;
    escape_value_next = escape_value;
    digit_count_next  = digit_count;
    byte_count_next   = byte_count;
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = '0;
    r1 = '0;
    e  = '0;
    bd = '0;
    is_oct = (item.in_byte >= 8'h30) && (item.in_byte <= 8'h37);
    hv     = hex_val(item.in_byte);
    dc_inc = 3'(digit_count) + 3'd1;
    ev_new = (mode == HEX) ? {escape_value[4:0], hv[3:0]}
                           : {escape_value[5:0], item.in_byte[2:0]};

    if (item.end_of_text) begin
      if (mode == OCT || mode == HEX) begin
        e  = emit_eval(escape_value[7:0], byte_count);
        v0 = 1'b1;
        r0 = e.res;
        byte_count_next = e.cnt;
        if (e.ok) begin
          v1 = 1'b1;
          r1 = mk(KIND_UNTERM, 8'd0, 9'd0);
        end
      end else if (mode != IDLE) begin
        v0 = 1'b1;
        r0 = mk(KIND_UNTERM, 8'd0, 9'd0);
      end
      mode_next = IDLE;
    end else if (item.start_literal) begin
      mode_next         = BODY;
      byte_count_next   = '0;
      escape_value_next = '0;
      digit_count_next  = '0;
    end else begin
      unique case (mode)
        BODY: begin
          bd = body_eval(item.in_byte, byte_count);
          v0 = bd.has;
          r0 = bd.res;
          mode_next       = bd.mode;
          byte_count_next = bd.cnt;
        end
        ESC: begin
          mode_next = BODY;
          if (is_oct) begin
            escape_value_next = {6'd0, item.in_byte[2:0]};
            digit_count_next  = 2'd1;
            mode_next         = OCT;
          end else if (item.in_byte == 8'h78) begin
            escape_value_next = '0;
            digit_count_next  = '0;
            mode_next         = HEX;
          end else if (item.in_byte == 8'h20 || item.in_byte == 8'h0a) begin
            // escaped space or line break is dropped
          end else begin
            e  = emit_eval((item.in_byte == 8'h6e) ? 8'h0a : item.in_byte, byte_count);
            v0 = 1'b1;
            r0 = e.res;
            byte_count_next = e.cnt;
            mode_next       = e.ok ? BODY : IDLE;
          end
        end
        OCT, HEX: begin
          if ((mode == OCT && is_oct) || (mode == HEX && hv[4])) begin
            escape_value_next = ev_new;
            digit_count_next  = dc_inc[1:0];
            if (dc_inc >= ((mode == OCT) ? 3'd3 : 3'd2)) begin
              digit_count_next = '0;
              e  = emit_eval(ev_new[7:0], byte_count);
              v0 = 1'b1;
              r0 = e.res;
              byte_count_next = e.cnt;
              mode_next       = e.ok ? BODY : IDLE;
            end
          end else begin
            // terminator: flush the escape, then decode the byte itself
            digit_count_next = '0;
            e  = emit_eval(escape_value[7:0], byte_count);
            v0 = 1'b1;
            r0 = e.res;
            byte_count_next = e.cnt;
            mode_next       = IDLE;
            if (e.ok) begin
              bd = body_eval(item.in_byte, e.cnt);
              v1 = bd.has;
              r1 = bd.res;
              mode_next       = bd.mode;
              byte_count_next = bd.cnt;
            end
          end
        end
        default: mode_next = IDLE;
      endcase
    end

    if (v1)      r1.last = 1'b1;
    else if (v0) r0.last = 1'b1;

    push.v0 = en & v0;
    push.v1 = en & v1;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= IDLE;
      escape_value <= '0;
      digit_count  <= '0;
      byte_count   <= '0;
    end else if (en) begin
      mode         <= mode_next;
      escape_value <= escape_value_next;
      digit_count  <= digit_count_next;
      byte_count   <= byte_count_next;
    end
  end

endmodule
`default_nettype wire

/* sv/sled_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_queue
// Four-entry result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module sled_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  sled_pkg::sled_push_t push,
  input  wire                  pop,
  output logic                 room,
  output logic                 nonempty,
  output sled_pkg::sled_out_t  head
);
  import sled_pkg::*;

  sled_out_t  mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       do_pop;

  assign do_pop   = pop & nonempty;
  assign nonempty = (count != 3'd0);
  // space for a two-result request without counting this cycle's pop
  assign room     = (count <= 3'd2);
  assign head     = mem[rd_ptr];

  always_comb begin
    count_next = count + 3'(push.v0) + 3'(push.v1) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.r0;
    if (push.v1) mem[wr_ptr + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + 2'(push.v0) + 2'(push.v1);
      rd_ptr <= rd_ptr + 2'(do_pop);
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

/* sv/string_literal_escape_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes string literal bodies byte by byte, resolving backslash escapes.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while item_stall is low. A request lands
// in an input register, is decoded there combinationally and its results
// (zero, one or two) are written to a four-entry result queue; results leave
// one per cycle while result_stall is low. Sustained rate is one request per
// cycle while each request makes at most one result and the sink does not
// stall; a request that makes two (an escape closed by a non-digit, or end
// of text with a pending escape) needs an extra slot, which the queue absorbs.
module string_literal_escape_decoder (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  sled_pkg::sled_in_t  item,
  output logic                result_valid,
  input  wire                 result_stall,
  output sled_pkg::sled_out_t result
);
  import sled_pkg::*;

  sled_in_t   item_q;
  logic       item_q_valid;
  logic       room, consume;
  sled_push_t push;

  assign consume    = item_q_valid & room;
  assign item_stall = item_q_valid & ~room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (consume) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) item_q <= item;
  end

  sled_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .en   (consume),
    .item (item_q),
    .push (push)
  );

  sled_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (~result_stall),
    .room     (room),
    .nonempty (result_valid),
    .head     (result)
  );

endmodule
`default_nettype wire

/* sv/sled_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_checker
// Port-level checks for the string literal escape decoder.
// ----------------------------------------------------------------------------
module sled_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 item_valid,
  input wire                 item_stall,
  input sled_pkg::sled_in_t  item,
  input wire                 result_valid,
  input wire                 result_stall,
  input sled_pkg::sled_out_t result
);
  import sled_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // complete, too long and unterminated always end a request's results
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_kind != KIND_BYTE |-> result.last)
    else $error("status result not last");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_kind != KIND_BYTE |-> result.out_byte == 8'd0)
    else $error("nonzero byte on status result");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_kind != KIND_COMPLETE |-> result.out_length == 9'd0)
    else $error("nonzero length outside completion");

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (.*);
`default_nettype wire

/* sim/sled_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_decode_checker
// Watches both channels of the escape decoder, predicts the decoded results of
// every accepted request and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module sled_decode_checker
  import sled_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_stall,
  input  sled_in_t  item,
  input  logic      result_valid,
  input  logic      result_stall,
  input  sled_out_t result,
  output int        fails,
  output int        outstanding
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX
  } lit_mode_e;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [9:0] LAST_SLOT  = 10'(MAX_LEN - 1);

  lit_mode_e  mode_r;
  logic [8:0] esc_val;
  logic [1:0] n_digits;
  logic [9:0] n_decoded;

  sled_out_t  step_q[$];
  sled_out_t  pending_decoded[$];

  initial fails = 0;
  initial outstanding = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [7:0] b,
                            input logic [8:0] len);
    sled_out_t r;
    r.out_kind   = kind;
    r.out_byte   = b;
    r.out_length = len;
    r.last       = 1'b0;
    step_q.push_back(r);
  endtask

  function automatic bit is_octal(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else begin
      return 5'd0;
    end
    return {1'b1, d[3:0]};
  endfunction

  // a decoded byte past the length limit closes the literal as too long
  task automatic emit_decoded(input logic [7:0] b, output bit ok);
    if (n_decoded >= LAST_SLOT) begin
      add_result(KIND_TOO_LONG, 8'd0, 9'd0);
      mode_r = MODE_IDLE;
      ok = 1'b0;
    end else begin
      add_result(KIND_BYTE, b, 9'd0);
      n_decoded++;
      ok = 1'b1;
    end
  endtask

  task automatic body_char(input logic [7:0] b);
    bit ok;
    if (b == CH_QUOTE) begin
      add_result(KIND_COMPLETE, 8'd0, n_decoded[8:0]);
      mode_r = MODE_IDLE;
    end else if (b == CH_BSLASH) begin
      mode_r = MODE_ESC;
    end else begin
      emit_decoded(b, ok);
    end
  endtask

  task automatic decode_source_byte(input sled_in_t req);
    logic [7:0] b;
    logic [4:0] h;
    bit         ok;
    sled_out_t  r;
    b = req.in_byte;
    step_q.delete();
    if (req.end_of_text) begin
      ok = 1'b1;
      if (mode_r == MODE_OCT || mode_r == MODE_HEX) begin
        emit_decoded(esc_val[7:0], ok);
      end
      if (ok && mode_r != MODE_IDLE) begin
        add_result(KIND_UNTERM, 8'd0, 9'd0);
      end
      mode_r = MODE_IDLE;
    end else if (req.start_literal) begin
      // a start inside an open literal silently drops it
      mode_r    = MODE_BODY;
      n_decoded = 10'd0;
      esc_val   = 9'd0;
      n_digits  = 2'd0;
    end else begin
      case (mode_r)
        MODE_BODY: begin
          body_char(b);
        end
        MODE_ESC: begin
          mode_r = MODE_BODY;
          if (is_octal(b)) begin
            esc_val  = {6'd0, b[2:0]};
            n_digits = 2'd1;
            mode_r   = MODE_OCT;
          end else if (b == CH_X) begin
            esc_val  = 9'd0;
            n_digits = 2'd0;
            mode_r   = MODE_HEX;
          end else if (b == CH_N) begin
            emit_decoded(CH_NEWLINE, ok);
          end else if (b != CH_SPACE && b != CH_NEWLINE) begin
            emit_decoded(b, ok);
          end
        end
        MODE_OCT: begin
          if (is_octal(b)) begin
            esc_val = {esc_val[5:0], b[2:0]};
            n_digits++;
            if (n_digits == 2'd3) begin
              mode_r   = MODE_BODY;
              n_digits = 2'd0;
              emit_decoded(esc_val[7:0], ok);
            end
          end else begin
            // pending escape goes out first, then the byte is decoded itself
            mode_r   = MODE_BODY;
            n_digits = 2'd0;
            emit_decoded(esc_val[7:0], ok);
            if (ok) body_char(b);
          end
        end
        MODE_HEX: begin
          h = hex_digit(b);
          if (h[4]) begin
            esc_val = {esc_val[4:0], h[3:0]};
            n_digits++;
            if (n_digits == 2'd2) begin
              mode_r   = MODE_BODY;
              n_digits = 2'd0;
              emit_decoded(esc_val[7:0], ok);
            end
          end else begin
            mode_r   = MODE_BODY;
            n_digits = 2'd0;
            emit_decoded(esc_val[7:0], ok);
            if (ok) body_char(b);
          end
        end
        default: begin
          mode_r = MODE_IDLE;
        end
      endcase
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    while (step_q.size() > 0) pending_decoded.push_back(step_q.pop_front());
  endtask

  always @(posedge clk) begin
    sled_out_t want;
    if (rst) begin
      mode_r    = MODE_IDLE;
      esc_val   = 9'd0;
      n_digits  = 2'd0;
      n_decoded = 10'd0;
      pending_decoded.delete();
    end else begin
      if (item_valid && !item_stall) decode_source_byte(item);
      if (result_valid && !result_stall) begin
        if (pending_decoded.size() == 0) begin
          report_mismatch("unexpected result, kind", int'(result.out_kind), -1);
        end else begin
          want = pending_decoded.pop_front();
          if (result.out_kind != want.out_kind)
            report_mismatch("out_kind", int'(result.out_kind), int'(want.out_kind));
          if (result.out_byte != want.out_byte)
            report_mismatch("out_byte", int'(result.out_byte), int'(want.out_byte));
          if (result.out_length != want.out_length)
            report_mismatch("out_length", int'(result.out_length),
                            int'(want.out_length));
          if (result.last != want.last)
            report_mismatch("last", int'(result.last), int'(want.last));
        end
      end
    end
    outstanding <= pending_decoded.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives string literals with every kind of escape into the decoder under
// varying source gaps and sink stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import sled_pkg::*;

  typedef enum int {
    PH_STEADY,
    PH_SRC_GAPS,
    PH_SINK_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_e;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam int         HOLD_CYCLES = 120;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  sled_in_t  item;
  logic      result_valid;
  logic      result_stall;
  sled_out_t result;
  int        fails;
  int        outstanding;

  phase_e    phase;
  int        idle_pct;
  int        stall_pct;
  int        items_sent;

  string_literal_escape_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sled_decode_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fails        (fails),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("string_literal_escape_decoder regression: fail");
    $finish;
  end

  // sink side: one long hold-off when pressure starts, random stalls otherwise
  initial begin
    bit held;
    held = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == PH_PRESSURE && !held) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] w;
    w = $urandom;
    return w[7:0];
  endfunction

  function automatic logic rand_bit();
    logic [31:0] w;
    w = $urandom;
    return w[0];
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = rand_byte(); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] octal_char();
    logic [31:0] w;
    w = $urandom;
    return {5'b00110, w[2:0]};
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic enter_phase(input phase_e p);
    phase = p;
    case (p)
      PH_SRC_GAPS:   begin idle_pct = 54; stall_pct = 0;  end
      PH_SINK_STALL: begin idle_pct = 0;  stall_pct = 54; end
      PH_BOTH:       begin idle_pct = 28; stall_pct = 28; end
      default:       begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic [7:0] b, input logic s, input logic e);
    sled_in_t r;
    r.in_byte       = b;
    r.start_literal = s;
    r.end_of_text   = e;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic send_body(input logic [7:0] b);
    send_req(b, 1'b0, 1'b0);
    items_sent++;
  endtask

  task automatic open_literal();
    send_req(rand_byte(), 1'b1, 1'b0);
    items_sent++;
  endtask

  task automatic random_element();
    int sel;
    int n;
    sel = $urandom_range(0, 19);
    if (sel < 9) begin
      send_body(plain_byte());
    end else if (sel < 11) begin
      send_body(rand_byte());
    end else begin
      send_body(CH_BSLASH);
      case ($urandom_range(0, 6))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) send_body(octal_char());
        end
        2, 3: begin
          send_body(CH_X);
          n = $urandom_range(0, 3);
          repeat (n) send_body(hex_char());
        end
        4: send_body(CH_N);
        5: send_body(rand_bit() ? CH_SPACE : CH_NEWLINE);
        default: send_body(rand_byte());
      endcase
    end
  endtask

  task automatic random_literal();
    int n_elems;
    int ending;
    // some noise between literals: stray bytes and end of text, idle or in an open literal
    if ($urandom_range(0, 9) == 0) send_req(rand_byte(), 1'b0, 1'b0);
    if ($urandom_range(0, 19) == 0) send_req(rand_byte(), rand_bit(), 1'b1);
    open_literal();
    n_elems = $urandom_range(0, 12);
    repeat (n_elems) random_element();
    ending = $urandom_range(0, 9);
    if (ending < 7) begin
      send_body(CH_QUOTE);
    end else if (ending < 9) begin
      send_req(rand_byte(), rand_bit(), 1'b1);
      items_sent++;
    end
  endtask

  // fills a literal up to the limit or just short of it, then a tail of random elements
  task automatic overflow_literal(input int margin);
    open_literal();
    repeat (MAX_LEN - 1 - margin) send_body(plain_byte());
    repeat ($urandom_range(2, 8)) random_element();
    if (rand_bit()) begin
      send_req(rand_byte(), 1'b0, 1'b1);
    end else begin
      send_body(CH_QUOTE);
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) random_literal();
  endtask

  task automatic directed_checks();
    open_literal();
    send_body(8'h00);
    send_body(8'hFF);
    // three octal digits overflowing a byte
    send_body(CH_BSLASH); send_body("7"); send_body("7"); send_body("7");
    // hex escape with no digits, closed by a non-digit
    send_body(CH_BSLASH); send_body(CH_X); send_body("G");
    send_body(CH_BSLASH); send_body(CH_N);
    send_body(CH_BSLASH); send_body(CH_SPACE);
    // pending octal escape ended by the closing quote
    send_body(CH_BSLASH); send_body("1"); send_body(CH_QUOTE);
    send_req("z", 1'b0, 1'b0);
    send_req(CH_QUOTE, 1'b1, 1'b1);
    // lone backslash at end of text
    open_literal();
    send_body(CH_BSLASH);
    send_req(8'hFF, 1'b0, 1'b1);
    // pending hex escape at end of text
    open_literal();
    send_body(CH_BSLASH); send_body(CH_X); send_body("a");
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    items_sent = 0;
    enter_phase(PH_STEADY);
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_checks();
    run_random(15);
    enter_phase(PH_SRC_GAPS);
    run_random(15);
    enter_phase(PH_SINK_STALL);
    run_random(15);
    enter_phase(PH_BOTH);
    run_random(15);
    enter_phase(PH_PRESSURE);
    run_random(30);
    enter_phase(PH_BOTH);
    overflow_literal($urandom_range(0, 3));

    item_valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("string_literal_escape_decoder regression: pass");
    end else begin
      $display("string_literal_escape_decoder regression: fail");
    end
    $finish;
  end

endmodule
